/* sv/cfd_pkg.sv */
`default_nettype none

package cfd_pkg;

    // Receiver phase.
    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_HEAD = 3'd1,
        PH_LENL = 3'd2,
        PH_DATA = 3'd3,
        PH_END  = 3'd4
    } t_phase;

    // Result kinds.
    localparam logic [1:0] K_PAYLOAD = 2'd0;
    localparam logic [1:0] K_DONE    = 2'd1;
    localparam logic [1:0] K_ERROR   = 2'd2;

    // Error codes.
    localparam logic [1:0] E_TIMEOUT = 2'd0;
    localparam logic [1:0] E_CHANNEL = 2'd1;
    localparam logic [1:0] E_LENGTH  = 2'd2;
    localparam logic [1:0] E_NOEND   = 2'd3;

    // Input operations.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_IDLE = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MARKER  = 2'd0;
    localparam logic [1:0] CFG_MAXLEN  = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;

    // Register reset values.
    localparam logic [7:0]  MARKER_RESET  = 8'd126;
    localparam logic [11:0] MAXLEN_RESET  = 12'd4095;
    localparam logic [31:0] TIMEOUT_RESET = 32'd0;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [3:0]  channel;
        logic [11:0] frame_length;
        logic [1:0]  error_code;
    } t_out;

    typedef struct packed {
        logic [7:0]  marker_byte;
        logic [11:0] max_payload;
        logic [31:0] timeout_ticks;
    } t_cfg;

endpackage

`default_nettype wire

/* sv/channel_frame_deframer_top.sv */
// Framed byte-stream receiver. Each input transfer is either a received byte or an idle
// tick; frames arrive as marker, channel/length-high byte, length-low byte, payload and a
// closing marker. Every payload byte produces a payload result as it arrives, a correct
// closing marker produces a done result carrying the channel and length, and a bad channel,
// an oversize length, a wrong closing byte or a run of idle ticks reaching timeout_ticks
// produces an error result and a return to hunting. Headers, idle ticks and hunting bytes
// produce no result. The block takes one input transfer every clock cycle unless
// stalled; the result of a transfer appears in the output register on the next cycle. The
// rate is set by the single per-byte state update, and the output register lets a new input
// transfer be taken in the same cycle in which the waiting result is taken. Configuration
// writes are accepted in every cycle and must only be made while the block is idle.
`default_nettype none

module channel_frame_deframer_top #(
    parameter int NUM_CHANNELS = 4
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    // Input channel.
    input  wire           i_in_valid,
    output logic          o_in_ready,
    input  cfd_pkg::t_in  i_in_data,
    // Result channel.
    output logic          o_out_valid,
    input  wire           i_out_ready,
    output cfd_pkg::t_out o_out_data,
    // Configuration write channel.
    input  wire           i_cfg_valid,
    output logic          o_cfg_ready,
    input  wire [1:0]     i_cfg_index,
    input  wire [31:0]    i_cfg_data
);

    cfd_pkg::t_cfg r_cfg;
    logic          r_out_valid;
    cfd_pkg::t_out r_out_data;

    logic          w_in_xfer;
    logic          w_res_valid;
    cfd_pkg::t_out w_res;

    // The result register frees up in the same cycle in which its result is taken.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Configuration registers. An index past the last register is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.marker_byte   <= cfd_pkg::MARKER_RESET;
            r_cfg.max_payload   <= cfd_pkg::MAXLEN_RESET;
            r_cfg.timeout_ticks <= cfd_pkg::TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                cfd_pkg::CFG_MARKER:  r_cfg.marker_byte   <= i_cfg_data[7:0];
                cfd_pkg::CFG_MAXLEN:  r_cfg.max_payload   <= i_cfg_data[11:0];
                cfd_pkg::CFG_TIMEOUT: r_cfg.timeout_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Receiver state and the per-transfer state update.
    cfd_fsm #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_in_xfer),
        .i_item      (i_in_data),
        .i_cfg       (r_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Result register. A transfer that causes no result leaves it empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_out_valid <= w_res_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_out_data <= w_res;
        end
    end

endmodule

`default_nettype wire

/* sv/cfd_fsm.sv */
`default_nettype none

module cfd_fsm #(
    parameter int NUM_CHANNELS = 4
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_step,
    input  cfd_pkg::t_in  i_item,
    input  cfd_pkg::t_cfg i_cfg,
    output logic          o_res_valid,
    output cfd_pkg::t_out o_res
);

    localparam logic [4:0] CHAN_LIMIT = 5'(NUM_CHANNELS);

    cfd_pkg::t_phase r_phase, n_phase;
    logic [3:0]      r_channel, n_channel;
    logic [11:0]     r_exp_len, n_exp_len;
    logic [11:0]     r_pos, n_pos;
    logic [31:0]     r_idle, n_idle;

    logic [31:0] w_idle_inc;
    logic        w_tmo_hit;
    logic        w_is_marker;
    logic [11:0] w_len_full;
    logic        w_len_bad;
    logic        w_chan_bad;
    logic [11:0] w_pos_inc;

    // The idle count saturates at its top value.
    assign w_idle_inc  = (r_idle != '1) ? r_idle + 32'd1 : r_idle;
    assign w_tmo_hit   = (i_cfg.timeout_ticks != '0) && (w_idle_inc >= i_cfg.timeout_ticks);
    assign w_is_marker = (i_item.rx_byte == i_cfg.marker_byte);
    assign w_len_full  = {r_exp_len[11:8], i_item.rx_byte};
    assign w_len_bad   = (w_len_full > i_cfg.max_payload);
    assign w_chan_bad  = ({1'b0, i_item.rx_byte[7:4]} >= CHAN_LIMIT);
    assign w_pos_inc   = r_pos + 12'd1;

    always_comb begin
        n_phase   = r_phase;
        n_channel = r_channel;
        n_exp_len = r_exp_len;
        n_pos     = r_pos;
        n_idle    = r_idle;
        if (i_item.op == cfd_pkg::OP_IDLE) begin
            if (i_cfg.timeout_ticks == '0) begin
                n_idle = '0;
            end else if (w_tmo_hit) begin
                n_idle  = '0;
                n_phase = cfd_pkg::PH_HUNT;
            end else begin
                n_idle = w_idle_inc;
            end
        end else begin
            n_idle = '0;
            unique case (r_phase)
                cfd_pkg::PH_HEAD: begin
                    if (!w_is_marker) begin
                        n_channel = i_item.rx_byte[7:4];
                        n_exp_len = {i_item.rx_byte[3:0], 8'd0};
                        n_phase   = w_chan_bad ? cfd_pkg::PH_HUNT : cfd_pkg::PH_LENL;
                    end
                end
                cfd_pkg::PH_LENL: begin
                    n_exp_len = w_len_full;
                    if (w_len_bad) begin
                        n_phase = cfd_pkg::PH_HUNT;
                    end else begin
                        n_pos   = '0;
                        n_phase = (w_len_full != '0) ? cfd_pkg::PH_DATA : cfd_pkg::PH_END;
                    end
                end
                cfd_pkg::PH_DATA: begin
                    n_pos = w_pos_inc;
                    if (w_pos_inc >= r_exp_len) begin
                        n_phase = cfd_pkg::PH_END;
                    end
                end
                cfd_pkg::PH_END: begin
                    n_phase = cfd_pkg::PH_HUNT;
                end
                default: begin
                    // Hunting, and any phase code that means nothing.
                    if (w_is_marker) begin
                        n_phase = cfd_pkg::PH_HEAD;
                        n_pos   = '0;
                    end else begin
                        n_phase = cfd_pkg::PH_HUNT;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.kind  = cfd_pkg::K_PAYLOAD;
        if (i_item.op == cfd_pkg::OP_IDLE) begin
            if (w_tmo_hit) begin
                o_res_valid      = 1'b1;
                o_res.kind       = cfd_pkg::K_ERROR;
                o_res.error_code = cfd_pkg::E_TIMEOUT;
            end
        end else begin
            unique case (r_phase)
                cfd_pkg::PH_HEAD: begin
                    if (!w_is_marker && w_chan_bad) begin
                        o_res_valid      = 1'b1;
                        o_res.kind       = cfd_pkg::K_ERROR;
                        o_res.error_code = cfd_pkg::E_CHANNEL;
                    end
                end
                cfd_pkg::PH_LENL: begin
                    if (w_len_bad) begin
                        o_res_valid      = 1'b1;
                        o_res.kind       = cfd_pkg::K_ERROR;
                        o_res.error_code = cfd_pkg::E_LENGTH;
                    end
                end
                cfd_pkg::PH_DATA: begin
                    o_res_valid        = 1'b1;
                    o_res.kind         = cfd_pkg::K_PAYLOAD;
                    o_res.payload_byte = i_item.rx_byte;
                end
                cfd_pkg::PH_END: begin
                    o_res_valid = 1'b1;
                    if (w_is_marker) begin
                        o_res.kind         = cfd_pkg::K_DONE;
                        o_res.frame_length = r_pos;
                    end else begin
                        o_res.kind       = cfd_pkg::K_ERROR;
                        o_res.error_code = cfd_pkg::E_NOEND;
                    end
                end
                default: begin
                    o_res_valid = 1'b0;
                end
            endcase
        end
        // Every result reports the channel as it stands after this byte.
        o_res.channel = n_channel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= cfd_pkg::PH_HUNT;
            r_channel <= '0;
            r_exp_len <= '0;
            r_pos     <= '0;
            r_idle    <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_channel <= n_channel;
            r_exp_len <= n_exp_len;
            r_pos     <= n_pos;
            r_idle    <= n_idle;
        end
    end

endmodule

`default_nettype wire

/* sv/cfd_checker.sv */
`default_nettype none

module cfd_checker (
    input wire           i_clk,
    input wire           i_rst_n,
    input wire           i_in_valid,
    input wire           o_in_ready,
    input cfd_pkg::t_in  i_in_data,
    input wire           o_out_valid,
    input wire           i_out_ready,
    input cfd_pkg::t_out o_out_data
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // No new input is taken while a result waits.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken over a waiting result");

    // Only defined result kinds are sent.
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.kind == cfd_pkg::K_PAYLOAD ||
                         o_out_data.kind == cfd_pkg::K_DONE ||
                         o_out_data.kind == cfd_pkg::K_ERROR))
        else $error("undefined result kind");

    // In a payload result, the length and error code fields read as zero.
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == cfd_pkg::K_PAYLOAD |->
            o_out_data.frame_length == '0 && o_out_data.error_code == '0)
        else $error("payload result carries stray fields");

    // An idle tick taken with an empty result register never yields a payload byte.
    a_idle_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.op == cfd_pkg::OP_IDLE |=>
            !(o_out_valid && o_out_data.kind == cfd_pkg::K_PAYLOAD &&
              $past(o_in_ready)))
        else $error("idle tick produced a payload byte");

endmodule

bind channel_frame_deframer_top cfd_checker u_cfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
